>>> rtl/core/bqcl_pkg.sv
`timescale 1ns / 1ps

package bqcl_pkg;

  localparam int CHANNEL_W = 3;
  localparam int SAMPLE_W = 16;
  localparam int LIGHT_W = 16;

  localparam int DEF_CHANNELS = 8;
  localparam int DEF_BEATS_PER_BAR = 4;
  localparam int DEF_TIMER_BITS = 24;

  // The decay step is 1.2/period in Q0.16, i.e. 393216 / (5 * period).
  localparam int DECAY_NUM = 393216;
  localparam int DECAY_NUM_W = 19;
  localparam int DECAY_DEN = 5;

  localparam logic [LIGHT_W-1:0] FULL_BRIGHT = '1;

  typedef struct packed {
    logic [CHANNEL_W-1:0]       channel;
    logic                       clock_level;
    logic                       button_level;
    logic                       cv_level;
    logic                       cv_connected;
    logic signed [SAMPLE_W-1:0] sample_in;
  } item_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0]       channel_out;
    logic signed [SAMPLE_W-1:0] gated_sample;
    logic                       feedback_high;
    logic [LIGHT_W-1:0]         light_level;
    logic                       gate_open;
    logic                       pending;
  } result_t;

  typedef struct packed {
    logic load_item;
    logic div_start;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/bqcl_div.sv
`timescale 1ns / 1ps

module bqcl_div #(
  parameter int DIV_W = 27
) (
  input  logic                              clk,
  input  logic                              start,
  input  logic                              step,
  input  logic [DIV_W-1:0]                  divisor,
  output logic [bqcl_pkg::DECAY_NUM_W-1:0]  quotient,
  output logic                              last
);
  import bqcl_pkg::*;

  localparam int CMP_W = (DIV_W > DECAY_NUM_W + 1) ? DIV_W : DECAY_NUM_W + 1;
  localparam int CNT_W = $clog2(DECAY_NUM_W);

  logic [CMP_W-1:0]       den;
  logic [CMP_W-1:0]       rem;
  logic [CMP_W-1:0]       rem_sh;
  logic [DECAY_NUM_W-1:0] q;
  logic [CNT_W-1:0]       cnt;

  assign rem_sh   = {rem[CMP_W-2:0], q[DECAY_NUM_W-1]};
  assign last     = (cnt == CNT_W'(DECAY_NUM_W - 1));
  assign quotient = q;

  // Restoring division of the fixed numerator, one quotient bit per step.
  always_ff @(posedge clk) begin
    if (start) begin
      den <= CMP_W'(divisor);
      rem <= '0;
      q   <= DECAY_NUM_W'(DECAY_NUM);
      cnt <= '0;
    end else if (step) begin
      if (rem_sh >= den) begin
        rem <= rem_sh - den;
        q   <= {q[DECAY_NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q   <= {q[DECAY_NUM_W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
    end
  end

endmodule

>>> rtl/core/bqcl_datapath.sv
`timescale 1ns / 1ps

module bqcl_datapath #(
  parameter int CHANNELS      = bqcl_pkg::DEF_CHANNELS,
  parameter int BEATS_PER_BAR = bqcl_pkg::DEF_BEATS_PER_BAR,
  parameter int TIMER_BITS    = bqcl_pkg::DEF_TIMER_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  bqcl_pkg::cmd_t    cmd,
  output bqcl_pkg::status_t status,
  input  bqcl_pkg::item_t   item,
  output bqcl_pkg::result_t result,
  output logic              result_valid,
  input  logic              result_stall
);
  import bqcl_pkg::*;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BEAT_W = $clog2(BEATS_PER_BAR + 1);
  localparam int DIV_W = TIMER_BITS + 3;

  logic                  clock_prev   [CHANNELS];
  logic                  button_prev  [CHANNELS];
  logic                  cv_prev      [CHANNELS];
  logic [BEAT_W-1:0]     beat_count   [CHANNELS];
  logic [TIMER_BITS-1:0] tick_timer   [CHANNELS];
  logic [TIMER_BITS-1:0] clock_period [CHANNELS];
  logic [LIGHT_W-1:0]    blink_bright [CHANNELS];
  logic                  request_flag [CHANNELS];
  logic                  gate_flag    [CHANNELS];
  logic                  hold_flag    [CHANNELS];

  item_t                 item_r;
  logic [CH_W-1:0]       idx;
  logic                  in_range;

  logic [BEAT_W-1:0]     w_beat;
  logic [TIMER_BITS-1:0] w_period;
  logic [TIMER_BITS-1:0] w_timer;
  logic [LIGHT_W-1:0]    w_bright;

  logic                  rise;
  logic [BEAT_W-1:0]     beat_adv;
  logic [TIMER_BITS-1:0] period_sel;
  logic [DIV_W-1:0]      divisor;
  logic [DECAY_NUM_W-1:0] quotient;
  logic                  div_last;

  logic [LIGHT_W-1:0]    bright_dec;
  logic [TIMER_BITS-1:0] timer_inc;
  logic                  beat_one;
  logic                  trig;
  logic                  cv_prev_next;
  logic                  req1;
  logic                  hold1;
  logic                  req2;
  logic                  gate2;
  logic                  hold2;
  logic                  fb;
  logic [LIGHT_W-1:0]    light;
  result_t               result_next;

  assign idx      = CH_W'(item_r.channel);
  assign in_range = (32'(item_r.channel) < 32'(CHANNELS));

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= item;
    end
  end

  // Clock edge handling, ahead of the decay division.
  assign rise       = item_r.clock_level & ~clock_prev[idx];
  assign beat_adv   = (beat_count[idx] < BEAT_W'(BEATS_PER_BAR)) ?
                      beat_count[idx] + 1'b1 : BEAT_W'(1);
  assign period_sel = rise ? tick_timer[idx] : clock_period[idx];
  assign divisor    = DIV_W'(period_sel) * DIV_W'(DECAY_DEN);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      w_beat   <= rise ? beat_adv : beat_count[idx];
      w_period <= period_sel;
      w_timer  <= rise ? '0 : tick_timer[idx];
      w_bright <= rise ? FULL_BRIGHT : blink_bright[idx];
    end
  end

  bqcl_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .divisor  (divisor),
    .quotient (quotient),
    .last     (div_last)
  );

  always_comb begin
    if (w_period == '0 || quotient >= DECAY_NUM_W'(w_bright)) begin
      bright_dec = '0;
    end else begin
      bright_dec = w_bright - LIGHT_W'(quotient);
    end
    timer_inc = (w_timer != {TIMER_BITS{1'b1}}) ? w_timer + 1'b1 : w_timer;
    beat_one  = (w_beat == BEAT_W'(1));

    trig = (item_r.button_level & ~button_prev[idx]) |
           (item_r.cv_connected & item_r.cv_level & ~cv_prev[idx]);
    cv_prev_next = item_r.cv_connected ? item_r.cv_level : cv_prev[idx];

    req1  = trig ? ~request_flag[idx] : request_flag[idx];
    hold1 = trig ? beat_one : hold_flag[idx];
    if (req1 && beat_one && !hold1) begin
      gate2 = ~gate_flag[idx];
      req2  = 1'b0;
    end else begin
      gate2 = gate_flag[idx];
      req2  = req1;
    end
    hold2 = hold1 & beat_one;

    if (gate2 && !req2) begin
      fb    = 1'b1;
      light = FULL_BRIGHT;
    end else if (req2) begin
      fb    = (timer_inc < (w_period >> 1));
      light = bright_dec;
    end else begin
      fb    = 1'b0;
      light = '0;
    end

    result_next             = '0;
    result_next.channel_out = item_r.channel;
    if (in_range) begin
      result_next.gated_sample  = gate2 ? item_r.sample_in : '0;
      result_next.feedback_high = fb;
      result_next.light_level   = light;
      result_next.gate_open     = gate2;
      result_next.pending       = req2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        clock_prev[i]   <= 1'b1;
        button_prev[i]  <= 1'b1;
        cv_prev[i]      <= 1'b1;
        beat_count[i]   <= BEAT_W'(1);
        tick_timer[i]   <= '0;
        clock_period[i] <= '0;
        blink_bright[i] <= '0;
        request_flag[i] <= 1'b0;
        gate_flag[i]    <= 1'b0;
        hold_flag[i]    <= 1'b0;
      end
    end else if (cmd.commit && in_range) begin
      clock_prev[idx]   <= item_r.clock_level;
      button_prev[idx]  <= item_r.button_level;
      cv_prev[idx]      <= cv_prev_next;
      beat_count[idx]   <= w_beat;
      tick_timer[idx]   <= timer_inc;
      clock_period[idx] <= w_period;
      blink_bright[idx] <= bright_dec;
      request_flag[idx] <= req2;
      gate_flag[idx]    <= gate2;
      hold_flag[idx]    <= hold2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result <= result_next;
    end
  end

  assign status.in_range = in_range;
  assign status.div_last = div_last;
  assign status.out_free = ~result_valid | ~result_stall;

endmodule

>>> rtl/core/bqcl_ctrl.sv
`timescale 1ns / 1ps

module bqcl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  output bqcl_pkg::cmd_t    cmd,
  input  bqcl_pkg::status_t status
);
  import bqcl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_CALC;
        end
      end
      S_CALC: begin
        cmd.div_start = 1'b1;
        state_next    = status.in_range ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign item_stall = (state != S_IDLE);

endmodule

>>> rtl/core/bar_quantized_channel_launcher_top.sv
`timescale 1ns / 1ps
// Channel  Handshake                   Payload
// item     item_valid / item_stall     item   (bqcl_pkg::item_t)
// result   result_valid / result_stall result (bqcl_pkg::result_t)
//
// A transaction on a valid channel passes through accepting the item,
// reading the channel state, 19 steps of the serial decay divider and
// write-back. Channel numbers of CHANNELS or more skip the divider.
// Reset is synchronous and restores every channel to its power-up state.
// A stalled result holds the write-back until the output register frees.

module bar_quantized_channel_launcher_top #(
  parameter int CHANNELS      = bqcl_pkg::DEF_CHANNELS,
  parameter int BEATS_PER_BAR = bqcl_pkg::DEF_BEATS_PER_BAR,
  parameter int TIMER_BITS    = bqcl_pkg::DEF_TIMER_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bqcl_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output bqcl_pkg::result_t result
);
  import bqcl_pkg::*;

  cmd_t    cmd;
  status_t status;

  bqcl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .status     (status)
  );

  bqcl_datapath #(
    .CHANNELS      (CHANNELS),
    .BEATS_PER_BAR (BEATS_PER_BAR),
    .TIMER_BITS    (TIMER_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("A second transaction was accepted while one is in progress.");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.out_free)
    else $error("A result was written over one that had not been taken.");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !cmd.div_start && !cmd.div_step && !cmd.load_item)
    else $error("Write-back overlapped another datapath command.");

  a_out_of_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && 32'(result.channel_out) >= 32'(CHANNELS)) |->
    (result.gated_sample == '0 && result.light_level == '0 &&
     !result.gate_open && !result.pending && !result.feedback_high))
    else $error("A result for an absent channel carried non-zero fields.");

endmodule
